// ----- rtl/stprs_pkg.sv -----
// Shared types and constants for the segment tree range-sum block.
// No dependencies; imported by the sequencer and the top level.
package stprs_pkg;

  localparam int SUM_W   = 48;  // node and result width, wraps
  localparam int AMT_W   = 32;  // signed add amount
  localparam int START_W = 10;
  localparam int STOP_W  = 11;
  localparam int CFG_W   = 11;  // leaves_in_use register

  // Item kind codes
  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Status from the tree sequencer to the top level
  typedef struct packed {
    logic busy;       // clearing pass or an item in progress
    logic sum_valid;  // query finished, sum presented this cycle
  } walk_stat_t;

endpackage

// ----- rtl/stprs_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module stprs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/stprs_walk.sv -----
// Tree sequencer: clearing pass, leaf-to-root add walk and range-sum walk
// over the node RAM. Depends on stprs_pkg and stprs_ram.
module stprs_walk
  import stprs_pkg::*;
#(
  parameter int LEAVES = 1024,
  localparam int DEPTH = 2 * LEAVES,
  localparam int IW = $clog2(DEPTH),
  localparam int AW = IW + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic             go_kind,
  input  logic [AW-1:0]    go_a,
  input  logic [AW-1:0]    go_b,
  input  logic [SUM_W-1:0] go_delta,
  input  logic             out_free,
  output walk_stat_t       stat,
  output logic [SUM_W-1:0] sum
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_ALEAF  = 8'b0000_0100,
    S_AWLEAF = 8'b0000_1000,
    S_AUP    = 8'b0001_0000,
    S_QA     = 8'b0010_0000,
    S_QB     = 8'b0100_0000,
    S_QOUT   = 8'b1000_0000
  } walk_state_t;

  walk_state_t      state_r, state_nxt;
  logic [IW-1:0]    clr_r, clr_nxt;
  logic             pend_r, pend_nxt;
  logic [AW-1:0]    a_r, a_nxt;
  logic [AW-1:0]    b_r, b_nxt;
  logic [SUM_W-1:0] acc_r, acc_nxt;
  logic [SUM_W-1:0] delta_r, delta_nxt;

  logic             we, re, q_re, sum_valid;
  logic [IW-1:0]    waddr, raddr;
  logic [SUM_W-1:0] wdata, rdata, acc_q;
  logic [AW-1:0]    up, bm;

  stprs_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_nodes (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // query accumulator folds in the read issued last cycle
  assign acc_q = pend_r ? acc_r + rdata : acc_r;
  assign up    = a_r >> 1;
  assign bm    = b_r - AW'(1);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    acc_nxt   = acc_r;
    delta_nxt = delta_r;
    we        = 1'b0;
    waddr     = clr_r;
    wdata     = '0;
    re        = 1'b0;
    q_re      = 1'b0;
    raddr     = a_r[IW-1:0];
    sum_valid = 1'b0;
    case (state_r)
      S_CLEAR: begin
        we      = 1'b1;
        clr_nxt = clr_r + IW'(1);
        if (clr_r == IW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (go) begin
          a_nxt     = go_a;
          b_nxt     = go_b;
          acc_nxt   = '0;
          delta_nxt = go_delta;
          state_nxt = (go_kind == KIND_ADD) ? S_ALEAF : S_QA;
        end
      end
      S_ALEAF: begin
        re        = 1'b1;
        state_nxt = S_AWLEAF;
      end
      S_AWLEAF: begin
        we      = 1'b1;
        waddr   = a_r[IW-1:0];
        wdata   = rdata + delta_r;
        acc_nxt = wdata;
        if (a_r == AW'(1)) begin
          state_nxt = S_IDLE;
        end else begin
          re        = 1'b1;
          raddr     = a_r[IW-1:0] ^ IW'(1);
          state_nxt = S_AUP;
        end
      end
      S_AUP: begin
        // rdata is the sibling of node a_r, acc_r the node itself
        we      = 1'b1;
        waddr   = up[IW-1:0];
        wdata   = acc_r + rdata;
        acc_nxt = wdata;
        a_nxt   = up;
        if (up == AW'(1)) begin
          state_nxt = S_IDLE;
        end else begin
          re    = 1'b1;
          raddr = up[IW-1:0] ^ IW'(1);
        end
      end
      S_QA: begin
        acc_nxt = acc_q;
        if (a_r >= b_r) begin
          state_nxt = S_QOUT;
        end else begin
          if (a_r[0]) begin
            re    = 1'b1;
            q_re  = 1'b1;
            a_nxt = a_r + AW'(1);
          end
          state_nxt = S_QB;
        end
      end
      S_QB: begin
        acc_nxt = acc_q;
        if (b_r[0]) begin
          re    = 1'b1;
          q_re  = 1'b1;
          raddr = bm[IW-1:0];
        end
        a_nxt     = a_r >> 1;
        b_nxt     = b_r >> 1;
        state_nxt = S_QA;
      end
      S_QOUT: begin
        acc_nxt = acc_q;
        if (out_free) begin
          sum_valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign pend_nxt = q_re;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    acc_r   <= acc_nxt;
    delta_r <= delta_nxt;
  end

  assign stat.busy      = (state_r != S_IDLE);
  assign stat.sum_valid = sum_valid;
  assign sum            = acc_q;

  // a walk never reads the entry it writes in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (we && re) |-> (waddr != raddr))
    else $error("node RAM read and write to same entry");

  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    go |-> (state_r == S_IDLE))
    else $error("item started while sequencer busy");

  a_pend_query: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_QA || state_r == S_QB || state_r == S_QOUT))
    else $error("pending query read outside a query walk");

  a_up_above_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_AUP) |-> (a_r > AW'(1)))
    else $error("add walk past the root");

  a_sum_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sum_valid |=> (state_r == S_IDLE))
    else $error("sequencer did not return to idle after a result");

endmodule

// ----- rtl/segment_tree_point_add_range_sum.sv -----
// Top level: point-add / range-sum segment tree with config register and
// registered result output. Depends on stprs_pkg and stprs_walk.
//
//   channel | ports                                   | beat carries
//   --------+-----------------------------------------+--------------------------
//   in      | in_valid/in_ready, in_kind, in_start_req,| one add or one query
//           | in_stop, in_amount                      |
//   out     | out_valid/out_ready, out_range_sum      | one query sum (48b, wraps)
//   cfg     | cfg_wr_en, cfg_wr_data                  | leaves_in_use, no wait
//
// Walks: an add reads its leaf, writes it back while reading the sibling, then
//   climbs a tree level per cycle as the sibling read and parent write overlap.
//   A query alternates its two states, S_QA and S_QB, at each level (one RAM
//   read port, up to two nodes per level). One item at a time.
// Reset: synchronous, active low. The node RAM is then zeroed by a clearing
//   pass over all 2*LEAVES entries, during which in_ready stays low.
// Stalls: a finished sum sits in the output register; the next beat is taken
//   while it waits. A query holds at its end only if that register is full.
// An add to a leaf at or beyond n is accepted and dropped.
module segment_tree_point_add_range_sum
  import stprs_pkg::*;
#(
  parameter int LEAVES = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_kind,
  input  logic [START_W-1:0]      in_start_req,
  input  logic [STOP_W-1:0]       in_stop,
  input  logic signed [AMT_W-1:0] in_amount,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SUM_W-1:0] out_range_sum,
  input  logic                    cfg_wr_en,
  input  logic [CFG_W-1:0]        cfg_wr_data
);

  localparam int DEPTH = 2 * LEAVES;
  localparam int IW    = $clog2(DEPTH);
  localparam int AW    = IW + 1;             // holds 2n, the query end bound
  localparam int CW    = (AW > CFG_W) ? AW : CFG_W;

  // leaves_in_use: default flag stands for the reset value LEAVES,
  // which need not fit the 11-bit register
  logic             cfg_dflt_r;
  logic [CFG_W-1:0] cfg_r;

  logic [CW-1:0]    cfg_c, n_c, start_c, stop_c, lo_c, hi_c, a_c, b_c;
  logic             drop, accept, go;
  logic [SUM_W-1:0] delta, sum;
  walk_stat_t       stat;

  logic             out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0] out_sum_r;
  logic             out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_dflt_r <= 1'b1;
    end else if (cfg_wr_en) begin
      cfg_dflt_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_wr_en) begin
      cfg_r <= cfg_wr_data;
    end
  end

  // live leaf count n, saturated into [1, LEAVES]
  assign cfg_c = CW'(cfg_r);
  always_comb begin
    if (cfg_dflt_r) begin
      n_c = CW'(LEAVES);
    end else if (cfg_c == '0) begin
      n_c = CW'(1);
    end else if (cfg_c > CW'(LEAVES)) begin
      n_c = CW'(LEAVES);
    end else begin
      n_c = cfg_c;
    end
  end

  // bounds clamped to n; an empty range ends the walk at once with 0
  assign start_c = CW'(in_start_req);
  assign stop_c  = CW'(in_stop);
  assign lo_c    = (start_c > n_c) ? n_c : start_c;
  assign hi_c    = (stop_c > n_c) ? n_c : stop_c;
  assign a_c     = lo_c + n_c;
  assign b_c     = hi_c + n_c;

  assign drop     = (in_kind == KIND_ADD) && (start_c >= n_c);
  assign in_ready = !stat.busy;
  assign accept   = in_valid && in_ready;
  assign go       = accept && !drop;

  assign delta = {{(SUM_W - AMT_W){in_amount[AMT_W-1]}}, in_amount};

  assign out_free = !out_valid_r || out_ready;

  stprs_walk #(.LEAVES(LEAVES)) u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .go_kind  (in_kind),
    .go_a     (a_c[AW-1:0]),
    .go_b     (b_c[AW-1:0]),
    .go_delta (delta),
    .out_free (out_free),
    .stat     (stat),
    .sum      (sum)
  );

  // result register
  always_comb begin
    if (stat.sum_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.sum_valid) begin
      out_sum_r <= sum;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_range_sum = out_sum_r;

endmodule

// ----- tb/segment_tree_point_add_range_sum_tb.sv -----
// Self-checking bench for segment_tree_point_add_range_sum: a directed table, then random
// add and query beats over a run of leaf counts, scored against an in-bench tree model.
// Depends on stprs_pkg and the block's RTL; reads no files.
module segment_tree_point_add_range_sum_tb
  import stprs_pkg::*;
();

  localparam int LEAVES      = 1024;
  // Longest item is a query at n = 1024, which walks the deepest tree.
  localparam int SETTLE      = 40;
  // Slowest correct case: the clearing pass after reset, the long receiver hold,
  // or the longest sender gap plus a query plus the longest stall. All fit easily.
  localparam int QUIET_MAX   = 10000;
  localparam int LONG_HOLD   = 300;
  localparam int RAND_ITEMS  = 105;  // counted beats per leaf-count phase
  localparam int CALM_ITEMS  = 150;  // last phase, no idling on either side
  localparam int MAX_REPORTS = 10;
  localparam int N_PHASES    = 13;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_op_t;

  // One row of the directed table. For ROW_CFG the register value rides in amount.
  typedef struct packed {
    row_op_t                 op;
    logic                    kind;
    logic [START_W-1:0]      start;
    logic [STOP_W-1:0]       stop;
    logic signed [AMT_W-1:0] amount;
    logic                    typed;  // sum below is the expected result
    logic signed [SUM_W-1:0] sum;
  } stim_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_kind = KIND_ADD;
  logic [START_W-1:0]      in_start_req = '0;
  logic [STOP_W-1:0]       in_stop = '0;
  logic signed [AMT_W-1:0] in_amount = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [SUM_W-1:0] out_range_sum;
  logic                    cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]        cfg_wr_data = '0;

  // A typed expectation travels alongside the input beat it belongs to.
  logic                    beat_typed = 1'b0;
  logic signed [SUM_W-1:0] beat_sum = '0;

  // Model state: node store, leaf-count register, queue of awaited sums.
  logic [SUM_W-1:0]        node_sum [2*LEAVES];
  logic [CFG_W-1:0]        leaf_reg;
  logic signed [SUM_W-1:0] sum_q [$];

  // Directed table, filled at the start of the stimulus.
  stim_row_t               plan [$];

  int err_count = 0;
  int sums_seen = 0;
  int quiet = 0;
  bit calm = 1'b0;
  bit held_long = 1'b0;
  int unsigned cur_n = LEAVES;  // sender's own view of the live leaf count

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  segment_tree_point_add_range_sum #(
    .LEAVES(LEAVES)
  ) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_start_req (in_start_req),
    .in_stop      (in_stop),
    .in_amount    (in_amount),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_range_sum(out_range_sum),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  // Live leaf count: 0 behaves as 1, anything above LEAVES saturates.
  function automatic int unsigned span(logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > LEAVES) return LEAVES;
    return 32'(v);
  endfunction

  // Appends one row to the directed table.
  function automatic void add_row(row_op_t op, logic kind, logic [START_W-1:0] start,
                                  logic [STOP_W-1:0] stop, logic signed [AMT_W-1:0] amt,
                                  logic typed, logic signed [SUM_W-1:0] sum);
    stim_row_t r;
    r.op     = op;
    r.kind   = kind;
    r.start  = start;
    r.stop   = stop;
    r.amount = amt;
    r.typed  = typed;
    r.sum    = sum;
    plan.insert(plan.size(), r);
  endfunction

  // Point add: bump the leaf, then rebuild each parent from its two children.
  function automatic void leaf_add(int unsigned n, int unsigned leaf,
                                   logic signed [AMT_W-1:0] amt);
    int unsigned k;
    k = leaf + n;
    node_sum[k] = node_sum[k] + {{(SUM_W-AMT_W){amt[AMT_W-1]}}, amt};
    while (k > 1) begin
      node_sum[k >> 1] = node_sum[k] + node_sum[k ^ 1];
      k = k >> 1;
    end
  endfunction

  // Half-open range sum, closing in from both ends a level at a time.
  function automatic logic [SUM_W-1:0] span_sum(int unsigned n, int unsigned lo,
                                                 int unsigned hi);
    logic [SUM_W-1:0] acc;
    int unsigned a, b;
    acc = '0;
    a = lo + n;
    b = hi + n;
    while (a < b) begin
      if ((a & 1) != 0) begin
        acc = acc + node_sum[a];
        a = a + 1;
      end
      if ((b & 1) != 0) begin
        b = b - 1;
        acc = acc + node_sum[b];
      end
      a = a >> 1;
      b = b >> 1;
    end
    return acc;
  endfunction

  function automatic void log_fault(string what);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%0t: %s", $time, what);
  endfunction

  // Scoreboard: everything is sampled at the rising edge, before this edge's
  // updates land, so the model sees exactly what the block saw.
  always @(posedge clk) begin : monitor
    int unsigned n, lo, hi;
    logic signed [SUM_W-1:0] want;
    if (!rst_n) begin
      foreach (node_sum[i]) node_sum[i] = '0;
      leaf_reg = CFG_W'(LEAVES);
      quiet = 0;
    end else begin
      quiet = quiet + 1;
      if (cfg_wr_en) begin
        leaf_reg = cfg_wr_data;
        quiet = 0;
      end
      if (in_valid && in_ready) begin
        quiet = 0;
        n = span(leaf_reg);
        if (in_kind == KIND_ADD) begin
          // an add past the last live leaf is dropped silently
          if (in_start_req < n) leaf_add(n, 32'(in_start_req), in_amount);
        end else begin
          lo = (in_start_req > n) ? n : 32'(in_start_req);
          hi = (in_stop > n) ? n : 32'(in_stop);
          want = (lo < hi) ? span_sum(n, lo, hi) : '0;
          sum_q.insert(sum_q.size(), beat_typed ? beat_sum : want);
        end
      end
      if (out_valid && out_ready) begin
        quiet = 0;
        sums_seen++;
        if (sum_q.size() == 0) begin
          log_fault($sformatf("sum beat with nothing awaited: got %0d", out_range_sum));
        end else begin
          want = sum_q.pop_front();
          if (out_range_sum !== want)
            log_fault($sformatf("range_sum mismatch: expected %0d, got %0d",
                                want, out_range_sum));
        end
      end
      if (quiet >= QUIET_MAX) begin
        $display("%0t: watchdog, no beat for %0d cycles", $time, quiet);
        $display("segment_tree_point_add_range_sum_tb failed");
        $finish;
      end
    end
  end

  // Sender side. Each task is entered just after a rising edge.
  task automatic send_beat(logic kind, logic [START_W-1:0] start, logic [STOP_W-1:0] stop,
                           logic signed [AMT_W-1:0] amt, logic typed,
                           logic signed [SUM_W-1:0] sum);
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_start_req <= start;
    in_stop      <= stop;
    in_amount    <= amt;
    beat_typed   <= typed;
    beat_sum     <= sum;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic sender_gap(int pct);
    if (!calm && $urandom_range(0, 99) < pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // One extra edge first so the monitor has logged the last accepted beat.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sum_q.size() != 0) @(posedge clk);
  endtask

  // Register writes only when idle; adds give no sum, so let any trailing one finish.
  task automatic write_leaves(logic [CFG_W-1:0] v);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_n = span(v);
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] leaf_plan [N_PHASES];
    logic kind;
    logic [START_W-1:0] start;
    logic [STOP_W-1:0] stop;
    logic signed [AMT_W-1:0] amt;
    int sel, items, quota, gap_pct;
    bit paused;

    // Directed table: reset state, field extremes, empty and clamped queries,
    // then leaf counts of 1, 0 (acts as 1) and 2047 (saturates) over live data.
    add_row(ROW_BEAT, KIND_QUERY, 10'd0,    11'd1024, 32'sd0, 1'b1, 48'sd0);
    add_row(ROW_BEAT, KIND_QUERY, 10'd1023, 11'd2047, 32'sd0, 1'b1, 48'sd0);
    add_row(ROW_BEAT, KIND_QUERY, 10'd5,    11'd5,    32'sd0, 1'b1, 48'sd0);
    add_row(ROW_BEAT, KIND_QUERY, 10'd1023, 11'd0,    32'sd0, 1'b1, 48'sd0);
    add_row(ROW_BEAT, KIND_ADD,   10'd0,    11'd0,    32'sh7FFF_FFFF, 1'b0, 48'sd0);
    add_row(ROW_BEAT, KIND_ADD,   10'd1023, 11'd2047, 32'sh8000_0000, 1'b0, 48'sd0);
    add_row(ROW_BEAT, KIND_ADD,   10'd512,  11'd1024, -32'sd1, 1'b0, 48'sd0);
    add_row(ROW_BEAT, KIND_QUERY, 10'd0,    11'd1,    32'sd0, 1'b1, 48'sd2147483647);
    add_row(ROW_BEAT, KIND_QUERY, 10'd1023, 11'd1024, 32'sd0, 1'b1,
            -48'sd2147483648);
    add_row(ROW_BEAT, KIND_QUERY, 10'd0,    11'd2047, 32'sd0, 1'b1, -48'sd2);
    add_row(ROW_BEAT, KIND_QUERY, 10'd1,    11'd1023, 32'sd0, 1'b1, -48'sd1);
    add_row(ROW_BEAT, KIND_QUERY, 10'd0,    11'd1023, 32'sd0, 1'b0, 48'sd0);
    add_row(ROW_CFG,  KIND_ADD,   10'd0,    11'd0,    32'sd1, 1'b0, 48'sd0);
    add_row(ROW_BEAT, KIND_ADD,   10'd1,    11'd0,    32'sd100, 1'b0, 48'sd0);
    add_row(ROW_BEAT, KIND_QUERY, 10'd0,    11'd1,    32'sd0, 1'b0, 48'sd0);
    add_row(ROW_BEAT, KIND_ADD,   10'd0,    11'd0,    32'sd5, 1'b0, 48'sd0);
    add_row(ROW_BEAT, KIND_QUERY, 10'd0,    11'd2047, 32'sd0, 1'b0, 48'sd0);
    add_row(ROW_BEAT, KIND_QUERY, 10'd1,    11'd1,    32'sd0, 1'b1, 48'sd0);
    add_row(ROW_CFG,  KIND_ADD,   10'd0,    11'd0,    32'sd0, 1'b0, 48'sd0);
    add_row(ROW_BEAT, KIND_QUERY, 10'd0,    11'd1,    32'sd0, 1'b0, 48'sd0);
    add_row(ROW_CFG,  KIND_ADD,   10'd0,    11'd0,    32'sd2047, 1'b0, 48'sd0);
    add_row(ROW_BEAT, KIND_QUERY, 10'd0,    11'd1024, 32'sd0, 1'b0, 48'sd0);
    add_row(ROW_BEAT, KIND_ADD,   10'd1023, 11'd0,    32'sd1, 1'b0, 48'sd0);
    add_row(ROW_BEAT, KIND_QUERY, 10'd512,  11'd1024, 32'sd0, 1'b0, 48'sd0);
    add_row(ROW_CFG,  KIND_ADD,   10'd0,    11'd0,    32'sd1024, 1'b0, 48'sd0);

    // Leaf counts for the random phases; the store is never cleared between them,
    // so each phase reads the previous phase's nodes under a new layout.
    leaf_plan[0]  = 11'd1024;
    leaf_plan[1]  = 11'd2;
    leaf_plan[2]  = 11'd3;
    leaf_plan[3]  = CFG_W'($urandom_range(4, 1023));
    leaf_plan[4]  = 11'd1;
    leaf_plan[5]  = 11'd16;
    leaf_plan[6]  = 11'd512;
    leaf_plan[7]  = 11'd1023;
    leaf_plan[8]  = 11'd0;
    leaf_plan[9]  = 11'd2047;
    leaf_plan[10] = CFG_W'($urandom_range(4, 1023));
    leaf_plan[11] = 11'd700;
    leaf_plan[12] = 11'd1024;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].op == ROW_CFG) begin
        write_leaves(plan[i].amount[CFG_W-1:0]);
      end else begin
        send_beat(plan[i].kind, plan[i].start, plan[i].stop, plan[i].amount,
                  plan[i].typed, plan[i].sum);
        sender_gap(30);
      end
    end

    paused = 1'b0;
    for (int p = 0; p < N_PHASES; p++) begin
      write_leaves(leaf_plan[p]);
      if (p == N_PHASES - 1) calm = 1'b1;
      quota   = calm ? CALM_ITEMS : RAND_ITEMS;
      gap_pct = calm ? 0 : $urandom_range(0, 45);
      items   = 0;
      while (items < quota) begin
        kind = ($urandom_range(0, 99) < 45) ? KIND_QUERY : KIND_ADD;

        // start: mostly a live leaf, sometimes the edges or past the end
        sel = $urandom_range(0, 19);
        if (sel == 0) start = '0;
        else if (sel == 1) start = '1;
        else if (sel == 2) start = START_W'(cur_n - 1);
        else if (sel == 3) start = START_W'((cur_n > 1023) ? 1023 : cur_n);
        else if (sel == 4) start = START_W'($urandom_range(0, 1023));
        else start = START_W'($urandom_range(0, cur_n - 1));

        // stop: wide and narrow ranges, empty ones, and values past n
        sel = $urandom_range(0, 19);
        if (sel == 0) stop = '1;
        else if (sel == 1) stop = STOP_W'(cur_n);
        else if (sel == 2) stop = STOP_W'($urandom_range(0, 2047));
        else if (sel == 3) stop = STOP_W'(start);
        else if (sel < 8) stop = STOP_W'(start + $urandom_range(1, 4));
        else stop = STOP_W'($urandom_range((start < cur_n) ? start + 1 : 0, cur_n));

        sel = $urandom_range(0, 19);
        if (sel == 0) amt = 32'sh7FFF_FFFF;
        else if (sel == 1) amt = 32'sh8000_0000;
        else if (sel == 2) amt = -32'sd1;
        else if (sel < 9) amt = $urandom;
        else amt = int'($urandom_range(0, 2000)) - 1000;

        send_beat(kind, start, stop, amt, 1'b0, '0);
        // adds past the live leaves do nothing, so they do not count
        if (kind == KIND_QUERY || start < cur_n) items++;
        // hold the input once mid-run until every awaited sum is back
        if (p == 4 && items == 50 && !paused) begin
          paused = 1'b1;
          wait_drained();
        end
        sender_gap(gap_pct);
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (err_count == 0 && sum_q.size() == 0) begin
      $display("segment_tree_point_add_range_sum_tb passed");
    end else begin
      $display("segment_tree_point_add_range_sum_tb failed");
    end
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold once enough sums have come,
  // while the sender keeps offering beats, so the output register fills and the
  // block backs up onto in_ready.
  initial begin : sink
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!held_long && sums_seen >= 150) begin
        held_long = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

endmodule
